// ===== hw/rtl/fatl_pkg.sv =====
package fatl_pkg;

	localparam int ENTRIES     = 128;
	localparam int VPN_BITS    = 36;
	localparam int PPN_BITS    = 32;
	localparam int OFFSET_BITS = 12;
	// levels of the log-depth prefix OR over the cell row
	localparam int LVL         = $clog2(ENTRIES);

	typedef struct packed {
		logic                valid;
		logic [VPN_BITS-1:0] tag;
		logic [PPN_BITS-1:0] ppn;
	} entry_t;

	typedef struct packed {
		logic cmp;
		logic upd;
		logic flush;
	} cell_ctl_t;

endpackage

// ===== hw/rtl/fatl_cell.sv =====
module fatl_cell import fatl_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  cell_ctl_t           ctl,
	input  logic [VPN_BITS-1:0] key,
	input  logic                shift,
	input  entry_t              nxt,
	output entry_t              ent,
	output logic                match
);

	logic                valid_q;
	logic [VPN_BITS-1:0] tag_q;
	logic [PPN_BITS-1:0] ppn_q;
	logic                match_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			match_q <= 1'b0;
		end else begin
			if (ctl.flush) begin
				valid_q <= 1'b0;
			end else if (ctl.upd && shift) begin
				valid_q <= nxt.valid;
			end
			if (ctl.cmp) begin
				match_q <= valid_q && (tag_q == key);
			end
		end
	end

	// contents move one place toward the least-recent end when shifting
	always_ff @(posedge clk) begin
		if (ctl.upd && shift) begin
			tag_q <= nxt.tag;
			ppn_q <= nxt.ppn;
		end
	end

	assign ent   = '{valid: valid_q, tag: tag_q, ppn: ppn_q};
	assign match = match_q;

endmodule

// ===== hw/rtl/fully_associative_tlb_lru.sv =====
// Fully associative TLB, 128 entries, LRU replacement. Entries are kept in a row of cells
// ordered by recency (cell 0 least recent, top cell most recent), so the victim on a miss
// is always cell 0 and a touched entry moves to the top while the cells above it shift down.
// A translate runs a compare in every cell, then select and prefix OR over the row, then a
// shift of the row; busy is high through these steps, done strobes after the shift, and a new
// start is taken only while busy is low. A flush clears all valid bits in the accept cycle,
// keeps the recency order, and its result strobes in the next cycle. done is high for one cycle
// per result, hit/phys_page_num/out_offset hold until the next; the receiver cannot stall it.
module fully_associative_tlb_lru import fatl_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic                   mode,
	input  logic [VPN_BITS-1:0]    virt_page_num,
	input  logic [OFFSET_BITS-1:0] va_offset,
	input  logic [PPN_BITS-1:0]    walk_phys_page,
	output logic                   done,
	output logic                   hit,
	output logic [PPN_BITS-1:0]    phys_page_num,
	output logic [OFFSET_BITS-1:0] out_offset
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_SEL  = 2'd2;
	localparam logic [1:0] ST_UPD  = 2'd3;

	logic [1:0]             state_q;
	logic [VPN_BITS-1:0]    vpn_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic [PPN_BITS-1:0]    walk_q;
	logic                   sel_hit_q;
	logic [PPN_BITS-1:0]    sel_ppn_q;
	logic [ENTRIES-1:0]     shift_q;
	logic                   done_q;
	logic                   hit_q;
	logic [PPN_BITS-1:0]    phys_q;
	logic [OFFSET_BITS-1:0] out_off_q;

	logic                   accept;
	cell_ctl_t              ctl;
	entry_t                 ent [ENTRIES];
	entry_t                 top_entry;
	logic [ENTRIES-1:0]     match;
	logic [ENTRIES-1:0]     pfx [LVL+1];
	logic                   hit_c;
	logic [PPN_BITS-1:0]    ppn_c;
	logic [PPN_BITS-1:0]    new_ppn;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;

	always_comb begin
		ctl.cmp   = (state_q == ST_CMP);
		ctl.upd   = (state_q == ST_UPD);
		ctl.flush = accept && mode;
	end

	assign new_ppn   = sel_hit_q ? sel_ppn_q : walk_q;
	assign top_entry = '{valid: 1'b1, tag: vpn_q, ppn: new_ppn};

	for (genvar k = 0; k < ENTRIES; k++) begin : g_cell
		entry_t nxt;
		if (k == ENTRIES - 1) begin : g_top
			assign nxt = top_entry;
		end else begin : g_mid
			assign nxt = ent[k+1];
		end
		fatl_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.key    (vpn_q),
			.shift  (shift_q[k]),
			.nxt    (nxt),
			.ent    (ent[k]),
			.match  (match[k])
		);
	end

	// at most one valid tag matches, so an AND-OR picks its page
	always_comb begin
		hit_c = |match;
		ppn_c = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			ppn_c = ppn_c | (match[k] ? ent[k].ppn : '0);
		end
	end

	// cell k shifts on a hit at or below it: prefix OR from the least-recent end
	always_comb begin
		pfx[0] = match;
		for (int d = 0; d < LVL; d++) begin
			for (int k = 0; k < ENTRIES; k++) begin
				if (k >= (1 << d)) begin
					pfx[d+1][k] = pfx[d][k] | pfx[d][k - (1 << d)];
				end else begin
					pfx[d+1][k] = pfx[d][k];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (mode) begin
							done_q <= 1'b1;
						end else begin
							state_q <= ST_CMP;
						end
					end
				end
				ST_CMP: begin
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					state_q <= ST_IDLE;
					done_q  <= 1'b1;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vpn_q  <= virt_page_num;
			off_q  <= va_offset;
			walk_q <= walk_phys_page;
		end
		if (state_q == ST_SEL) begin
			sel_hit_q <= hit_c;
			sel_ppn_q <= ppn_c;
			shift_q   <= hit_c ? pfx[LVL] : '1;
		end
		if (accept && mode) begin
			hit_q     <= 1'b0;
			phys_q    <= '0;
			out_off_q <= va_offset;
		end else if (state_q == ST_UPD) begin
			hit_q     <= sel_hit_q;
			phys_q    <= new_ppn;
			out_off_q <= off_q;
		end
	end

	assign done          = done_q;
	assign hit           = hit_q;
	assign phys_page_num = phys_q;
	assign out_offset    = out_off_q;

endmodule
